/* hdl/rwst_pkg.sv */
// ----------------------------------------------------------------------------
// Random walk spanning tree maze package
// Shared widths, codes and the structs passed between the pipeline stages.
// ----------------------------------------------------------------------------
package rwst_pkg;

    localparam int MAX_CELLS_DEFAULT = 32;

    localparam int CELLS_W     = 6;
    localparam int COORD_W     = 6;
    localparam int TOTAL_OUT_W = 11;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_PAD_W   = OUT_DATA_W - (4 * COORD_W + 3 + TOTAL_OUT_W);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CELLS_PER_SIDE = 1'b0;

    localparam int EPOCH_W = 4;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    localparam logic KIND_START = 1'b0;

    typedef enum logic [1:0] {
        DIR_COL_INC = 2'd0,
        DIR_ROW_INC = 2'd1,
        DIR_COL_DEC = 2'd2,
        DIR_ROW_DEC = 2'd3
    } dir_t;

    typedef struct packed {
        logic               start;
        logic               moved;
        logic [COORD_W-1:0] walker_row;
        logic [COORD_W-1:0] walker_col;
        logic [COORD_W-1:0] wall_row;
        logic [COORD_W-1:0] wall_col;
        logic [EPOCH_W-1:0] epoch;
    } step_pay_t;

    typedef struct packed {
        logic accept;
        logic hold;
        logic full;
    } mark_stat_t;

endpackage

/* hdl/rwst_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rwst_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/rwst_cfg.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// APB register holding the cells per side, with the clamped size and the
// cell total derived at write time.
// ----------------------------------------------------------------------------
module rwst_cfg #(
    parameter int MAX_CELLS_PER_SIDE = rwst_pkg::MAX_CELLS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rwst_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rwst_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rwst_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic [$clog2(MAX_CELLS_PER_SIDE+1)-1:0] n_cells,
    output logic [$clog2(MAX_CELLS_PER_SIDE*MAX_CELLS_PER_SIDE+1)-1:0] total
);

    import rwst_pkg::*;

    localparam int NW = $clog2(MAX_CELLS_PER_SIDE + 1);
    localparam int TW = $clog2(MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE + 1);

    logic [CELLS_W-1:0] cells_reg, cells_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [TW-1:0]      total_reg, total_next;
    logic               wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1] == REG_CELLS_PER_SIDE);

    always_comb
    begin
        cells_next = cells_reg;
        n_next     = n_reg;
        total_next = total_reg;
        if (wr_hit)
        begin
            cells_next = pwdata[CELLS_W-1:0];
            if (int'(cells_next) < 2)
            begin
                n_next = NW'(2);
            end
            else if (int'(cells_next) > MAX_CELLS_PER_SIDE)
            begin
                n_next = NW'(MAX_CELLS_PER_SIDE);
            end
            else
            begin
                n_next = NW'(cells_next);
            end
            total_next = TW'(n_next) * TW'(n_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_reg <= CELLS_W'(2);
            n_reg     <= NW'(2);
            total_reg <= TW'(4);
        end
        else
        begin
            cells_reg <= cells_next;
            n_reg     <= n_next;
            total_reg <= total_next;
        end
    end

    assign prdata  = (paddr[APB_ADDR_W-1] == REG_CELLS_PER_SIDE) ?
                     APB_DATA_W'(cells_reg) : '0;
    assign n_cells = n_reg;
    assign total   = total_reg;

endmodule

/* hdl/rwst_step.sv */
// ----------------------------------------------------------------------------
// Walker step stage
// Input register, walker position, bounds check, map read address, epoch
// counter and the map clearing sweep.
// ----------------------------------------------------------------------------
module rwst_step #(
    parameter int MAX_CELLS_PER_SIDE = rwst_pkg::MAX_CELLS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rwst_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                 s_tuser,
    input  logic [$clog2(MAX_CELLS_PER_SIDE+1)-1:0] n_cells,
    input  rwst_pkg::mark_stat_t                 stat,
    output logic                                 b_load,
    output rwst_pkg::step_pay_t                  b_pay,
    output logic [$clog2(MAX_CELLS_PER_SIDE*MAX_CELLS_PER_SIDE)-1:0] rd_addr,
    output logic                                 clearing,
    output logic [$clog2(MAX_CELLS_PER_SIDE*MAX_CELLS_PER_SIDE)-1:0] clr_addr
);

    import rwst_pkg::*;

    localparam int CW    = $clog2(MAX_CELLS_PER_SIDE);
    localparam int XW    = CW + 1;
    localparam int DEPTH = MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_CLEAR = 2'b10
    } walk_state_t;

    walk_state_t        state_reg, state_next;
    logic               a_valid_reg, a_valid_next;
    logic               a_kind_reg;
    logic [1:0]         a_dir_reg;
    logic [CW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;

    logic          a_adv;
    logic          a_start;
    logic          dir_ok;
    logic          in_bounds;
    logic          move;
    logic [XW-1:0] tr, tc;
    logic [CW-1:0] nr, nc;
    logic [CW-1:0] out_row, out_col;

    assign a_adv    = a_valid_reg && stat.accept && !stat.hold && (state_reg == ST_RUN);
    assign s_tready = (state_reg == ST_RUN) && (!a_valid_reg || a_adv);
    assign a_start  = (a_kind_reg == KIND_START);

    always_comb
    begin
        tr     = XW'(row_reg);
        tc     = XW'(col_reg);
        dir_ok = 1'b1;
        case (dir_t'(a_dir_reg))
            DIR_COL_INC: tc = XW'(col_reg) + XW'(1);
            DIR_ROW_INC: tr = XW'(row_reg) + XW'(1);
            DIR_COL_DEC:
            begin
                dir_ok = (col_reg != '0);
                tc     = XW'(col_reg) - XW'(1);
            end
            DIR_ROW_DEC:
            begin
                dir_ok = (row_reg != '0);
                tr     = XW'(row_reg) - XW'(1);
            end
            default: dir_ok = 1'b0;
        endcase
    end

    assign in_bounds = dir_ok && (tr < XW'(n_cells)) && (tc < XW'(n_cells));
    assign move      = !a_start && !stat.full && in_bounds;
    assign nr        = tr[CW-1:0];
    assign nc        = tc[CW-1:0];
    assign rd_addr   = AW'(nr * MAX_CELLS_PER_SIDE + nc);

    always_comb
    begin
        if (a_start)
        begin
            out_row = '0;
            out_col = '0;
        end
        else if (move)
        begin
            out_row = nr;
            out_col = nc;
        end
        else
        begin
            out_row = row_reg;
            out_col = col_reg;
        end
    end

    assign b_load           = a_adv;
    assign b_pay.start      = a_start;
    assign b_pay.moved      = move;
    assign b_pay.walker_row = COORD_W'({out_row, 1'b1});
    assign b_pay.walker_col = COORD_W'({out_col, 1'b1});
    assign b_pay.wall_row   = COORD_W'(row_reg) + COORD_W'(nr) + COORD_W'(1);
    assign b_pay.wall_col   = COORD_W'(col_reg) + COORD_W'(nc) + COORD_W'(1);
    assign b_pay.epoch      = epoch_reg;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        epoch_next   = epoch_reg;
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        if (a_adv)
        begin
            a_valid_next = 1'b0;
            row_next     = out_row;
            col_next     = out_col;
            if (a_start)
            begin
                if (epoch_reg == EPOCH_LAST)
                begin
                    epoch_next   = EPOCH_FIRST;
                    state_next   = ST_CLEAR;
                    clr_cnt_next = '0;
                end
                else
                begin
                    epoch_next = epoch_reg + EPOCH_W'(1);
                end
            end
        end
        if (s_tvalid && s_tready)
        begin
            a_valid_next = 1'b1;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:  ;
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            a_valid_reg <= 1'b0;
            row_reg     <= '0;
            col_reg     <= '0;
            epoch_reg   <= EPOCH_FIRST;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            a_valid_reg <= a_valid_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            epoch_reg   <= epoch_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            a_kind_reg <= s_tuser;
            a_dir_reg  <= s_tdata[1:0];
        end
    end

    assign clearing = (state_reg == ST_CLEAR);
    assign clr_addr = clr_cnt_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!s_tready && !a_adv))
        else $error("item taken during the map clearing sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch reached the never-written code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (a_adv && a_start) |=> (row_reg == '0 && col_reg == '0))
        else $error("start item did not return the walker to the corner");

endmodule

/* hdl/rwst_mark.sv */
// ----------------------------------------------------------------------------
// Visit marking stage
// Resolves the visited bit of the target cell, counts visited cells, writes
// the map and holds the result register.
// ----------------------------------------------------------------------------
module rwst_mark #(
    parameter int MAX_CELLS_PER_SIDE = rwst_pkg::MAX_CELLS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 b_load,
    input  rwst_pkg::step_pay_t                  b_pay,
    input  logic [$clog2(MAX_CELLS_PER_SIDE*MAX_CELLS_PER_SIDE)-1:0] b_addr,
    input  logic [rwst_pkg::EPOCH_W-1:0]         rd_data,
    input  logic                                 clearing,
    input  logic [$clog2(MAX_CELLS_PER_SIDE*MAX_CELLS_PER_SIDE+1)-1:0] total,
    output rwst_pkg::mark_stat_t                 stat,
    output logic                                 wr_en,
    output logic [$clog2(MAX_CELLS_PER_SIDE*MAX_CELLS_PER_SIDE)-1:0] wr_addr,
    output logic [rwst_pkg::EPOCH_W-1:0]         wr_data,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rwst_pkg::OUT_DATA_W-1:0]      m_tdata
);

    import rwst_pkg::*;

    localparam int DEPTH = MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(DEPTH + 1);

    logic               b_valid_reg, b_valid_next;
    step_pay_t          b_pay_reg;
    logic [AW-1:0]      b_addr_reg;
    logic               fwd_valid_reg, fwd_valid_next;
    logic [AW-1:0]      fwd_addr_reg;
    logic [EPOCH_W-1:0] fwd_epoch_reg;
    logic [TW-1:0]      count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic               b_adv;
    logic               visited;
    logic               carve;
    logic               finished;
    logic [TW-1:0]      count_after;
    logic [TW-1:0]      count_eff;
    logic [COORD_W-1:0] wall_row, wall_col;

    assign b_adv = b_valid_reg && (!out_valid_reg || m_tready);

    // Cell (0,0) always counts as visited and is never written by a step.
    assign visited = (b_addr_reg == '0)
                     || (rd_data == b_pay_reg.epoch)
                     || (fwd_valid_reg && (fwd_addr_reg == b_addr_reg)
                         && (fwd_epoch_reg == b_pay_reg.epoch));
    assign carve       = b_pay_reg.moved && !visited;
    assign count_after = b_pay_reg.start ? TW'(1) : count_reg + TW'(carve);
    assign finished    = (count_after >= total);
    assign wall_row    = carve ? b_pay_reg.wall_row : '0;
    assign wall_col    = carve ? b_pay_reg.wall_col : '0;

    assign count_eff   = (b_valid_reg && b_pay_reg.start) ? TW'(1) : count_reg;
    assign stat.accept = !b_valid_reg || b_adv;
    assign stat.hold   = b_valid_reg && b_pay_reg.moved && (count_reg + TW'(1) == total);
    assign stat.full   = (count_eff >= total);

    assign wr_en   = b_adv && carve && !clearing;
    assign wr_addr = b_addr_reg;
    assign wr_data = b_pay_reg.epoch;

    assign out_data_next = {OUT_PAD_W'(0), TOTAL_OUT_W'(count_after), finished,
                            wall_col, wall_row, b_pay_reg.start | carve,
                            b_pay_reg.moved, b_pay_reg.walker_col,
                            b_pay_reg.walker_row};

    always_comb
    begin
        b_valid_next   = b_valid_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        fwd_valid_next = fwd_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (b_adv)
        begin
            b_valid_next   = 1'b0;
            out_valid_next = 1'b1;
            count_next     = count_after;
        end
        if (b_load)
        begin
            b_valid_next = 1'b1;
        end
        if (clearing)
        begin
            fwd_valid_next = 1'b0;
        end
        else if (wr_en)
        begin
            fwd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            count_reg     <= TW'(1);
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_pay_reg  <= b_pay;
            b_addr_reg <= b_addr;
        end
        if (wr_en)
        begin
            fwd_addr_reg  <= b_addr_reg;
            fwd_epoch_reg <= b_pay_reg.epoch;
        end
        if (b_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && !b_pay_reg.start) |=>
            (count_reg == $past(count_reg) || count_reg == $past(count_reg) + TW'(1)))
        else $error("visited count moved by more than one cell on a step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && b_pay_reg.start) |=> (count_reg == TW'(1)))
        else $error("start item did not reset the visited count");

endmodule

/* hdl/random_walk_spanning_tree_maze_unit.sv */
// ----------------------------------------------------------------------------
// Random walk spanning tree maze unit
// Aldous-Broder maze carving: one random-walk step per item on a square grid
// of cells, with the visited map kept in an on-chip RAM.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock while s_tready is high and returns one
// result per item, which reaches the output after passing the input register,
// the map read stage and the result register.
// A step that follows a step able to visit the last open cell waits until
// that cell's visited bit is resolved. The visited map holds an epoch tag per
// cell, so a start item takes effect at once; after reset, and after every
// fifteenth start item when the tag wraps, the map RAM is swept clean over
// all MAX_CELLS_PER_SIDE squared addresses (1024 by default), during which
// s_tready stays low. Configuration writes are accepted at any time.
module random_walk_spanning_tree_maze_unit #(
    parameter int MAX_CELLS_PER_SIDE = rwst_pkg::MAX_CELLS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: direction [1:0], zero fill above.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rwst_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser: kind [0].
    input  logic                            s_tuser,
    // m_tdata: walker_row [5:0], walker_col [11:6], moved [12], carved [13],
    // wall_row [19:14], wall_col [25:20], finished [26], visited_total [37:27].
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rwst_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rwst_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rwst_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rwst_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    import rwst_pkg::*;

    localparam int NW    = $clog2(MAX_CELLS_PER_SIDE + 1);
    localparam int DEPTH = MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(DEPTH + 1);

    logic [NW-1:0]      n_cells;
    logic [TW-1:0]      total;
    mark_stat_t         stat;
    logic               b_load;
    step_pay_t          b_pay;
    logic [AW-1:0]      rd_addr;
    logic [EPOCH_W-1:0] rd_data;
    logic               clearing;
    logic [AW-1:0]      clr_addr;
    logic               mk_wr_en;
    logic [AW-1:0]      mk_wr_addr;
    logic [EPOCH_W-1:0] mk_wr_data;
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [EPOCH_W-1:0] ram_wr_data;

    rwst_cfg #(
        .MAX_CELLS_PER_SIDE(MAX_CELLS_PER_SIDE)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .n_cells (n_cells),
        .total   (total)
    );

    rwst_step #(
        .MAX_CELLS_PER_SIDE(MAX_CELLS_PER_SIDE)
    ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .n_cells  (n_cells),
        .stat     (stat),
        .b_load   (b_load),
        .b_pay    (b_pay),
        .rd_addr  (rd_addr),
        .clearing (clearing),
        .clr_addr (clr_addr)
    );

    assign ram_wr_en   = clearing || mk_wr_en;
    assign ram_wr_addr = clearing ? clr_addr : mk_wr_addr;
    assign ram_wr_data = clearing ? '0 : mk_wr_data;

    rwst_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (DEPTH)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (b_load),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rwst_mark #(
        .MAX_CELLS_PER_SIDE(MAX_CELLS_PER_SIDE)
    ) u_mark (
        .clk      (clk),
        .rst_n    (rst_n),
        .b_load   (b_load),
        .b_pay    (b_pay),
        .b_addr   (rd_addr),
        .rd_data  (rd_data),
        .clearing (clearing),
        .total    (total),
        .stat     (stat),
        .wr_en    (mk_wr_en),
        .wr_addr  (mk_wr_addr),
        .wr_data  (mk_wr_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
